### hw/rtl/mbrd_pkg.sv
// shared types, constants and codes for the mbr partition table detector
`default_nettype none

package mbrd_pkg;

  // longest sector tracked; the byte position saturates here
  localparam int unsigned MAX_SECTOR_BYTES = 4096;
  localparam int unsigned POS_W            = $clog2(MAX_SECTOR_BYTES + 1);

  // sector layout
  localparam int unsigned TABLE_OFFSET     = 446;
  localparam int unsigned SIG_OFFSET       = 510;
  localparam int unsigned MIN_SECTOR_BYTES = 512;
  localparam int unsigned NUM_ENTRIES      = 4;
  localparam int unsigned ENTRY_BYTES      = 16;
  localparam int unsigned TABLE_BYTES      = NUM_ENTRIES * ENTRY_BYTES;
  localparam int unsigned TBL_AW           = $clog2(TABLE_BYTES);
  localparam int unsigned ENT_W            = $clog2(NUM_ENTRIES);
  localparam int unsigned ENT_OFS_W        = $clog2(ENTRY_BYTES);
  localparam int unsigned CNT_W            = $clog2(NUM_ENTRIES + 1);

  // byte offsets inside one table entry (start and count are word aligned)
  localparam logic [ENT_OFS_W-1:0] OFS_FLAG      = ENT_OFS_W'(0);
  localparam logic [ENT_OFS_W-1:0] OFS_TYPE      = ENT_OFS_W'(4);
  localparam logic [ENT_OFS_W-1:0] OFS_START     = ENT_OFS_W'(8);
  localparam logic [ENT_OFS_W-1:0] OFS_START_END = ENT_OFS_W'(11);
  localparam logic [ENT_OFS_W-1:0] OFS_COUNT     = ENT_OFS_W'(12);
  localparam logic [ENT_OFS_W-1:0] OFS_COUNT_END = ENT_OFS_W'(15);

  // marker bytes
  localparam logic [7:0] SIG_LOW_BYTE   = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE  = 8'hAA;
  localparam int unsigned ACTIVE_BIT    = 7;
  localparam logic [7:0] TYPE_HYBRID_CD = 8'hCD;
  localparam logic [7:0] TYPE_GPT       = 8'hEE;

  // configuration registers
  localparam int unsigned SECTOR_SIZE_W = 16;
  localparam int unsigned DRIVE_COUNT_W = 48;
  localparam int unsigned APB_DW        = 64;
  localparam int unsigned APB_AW        = 4;
  localparam logic [SECTOR_SIZE_W-1:0] SECTOR_SIZE_RESET = SECTOR_SIZE_W'(512);
  localparam logic REG_IDX_SECTOR_SIZE = 1'b0;
  localparam logic REG_IDX_DRIVE_COUNT = 1'b1;

  // job queue between front and back (depth of two or more)
  localparam int unsigned JOBQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OUT_NO_VOLUME   = 2'd0,
    OUT_WHOLE_DRIVE = 2'd1,
    OUT_PARTITION   = 2'd2,
    OUT_READ_ERROR  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    JOB_NO_VOLUME  = 2'd0,
    JOB_READ_ERROR = 2'd1,
    JOB_TABLE      = 2'd2
  } job_e;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_READ   = 3'd1,
    B_EVAL   = 3'd2,
    B_DECIDE = 3'd3,
    B_EMIT   = 3'd4
  } back_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       read_error;
    logic       sector_end;
  } in_item_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [1:0]  slot;
    logic [31:0] start_lba;
    logic [31:0] lba_count;
    logic [7:0]  type_id;
    logic        is_final;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic valid;
    job_e kind;
  } job_head_t;

endpackage

`default_nettype wire

### hw/rtl/mbrd_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module mbrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mbrd_front.sv
// front end: byte intake, table and signature capture, end of sector classification
`default_nettype none

module mbrd_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire mbrd_pkg::in_item_t                in_data_i,
  input  wire logic [mbrd_pkg::SECTOR_SIZE_W-1:0] sector_size_i,
  input  wire logic                              q_full_i,
  output      logic                              push_o,
  output      mbrd_pkg::job_e                    push_kind_o,
  input  wire logic                              release_i,
  output      mbrd_pkg::tbl_wr_t                 tbl_wr_o
);

  import mbrd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sig_lo_q, sig_lo_d;
  logic [7:0]       sig_hi_q, sig_hi_d;
  logic             lock_q, lock_d;
  logic             in_table;
  logic             accept;
  logic             sector_done;
  logic             sig_ok;

  // position decode
  assign in_table = (pos_q >= POS_W'(TABLE_OFFSET)) && (pos_q < POS_W'(SIG_OFFSET));

  // hold off while the queue is full, or while the back still reads the table
  assign in_stall_o  = q_full_i || (lock_q && in_table);
  assign accept      = in_valid_i && !in_stall_o;
  assign sector_done = in_data_i.read_error || in_data_i.sector_end;

  // table bytes go to the store
  assign tbl_wr_o.en   = accept && !in_data_i.read_error && in_table;
  assign tbl_wr_o.addr = TBL_AW'(pos_q - POS_W'(TABLE_OFFSET));
  assign tbl_wr_o.data = in_data_i.data_byte;

  // signature bytes including the one in this transfer
  always_comb begin
    sig_lo_d = sig_lo_q;
    sig_hi_d = sig_hi_q;
    if (!in_data_i.read_error && pos_q == POS_W'(SIG_OFFSET)) begin
      sig_lo_d = in_data_i.data_byte;
    end
    if (!in_data_i.read_error && pos_q == POS_W'(SIG_OFFSET + 1)) begin
      sig_hi_d = in_data_i.data_byte;
    end
  end

  assign sig_ok = (sig_lo_d == SIG_LOW_BYTE) && (sig_hi_d == SIG_HIGH_BYTE);

  // end of sector classification
  always_comb begin
    if (sector_size_i < SECTOR_SIZE_W'(MIN_SECTOR_BYTES)) begin
      push_kind_o = JOB_NO_VOLUME;
    end else if (in_data_i.read_error) begin
      push_kind_o = JOB_READ_ERROR;
    end else if (!sig_ok) begin
      push_kind_o = JOB_NO_VOLUME;
    end else begin
      push_kind_o = JOB_TABLE;
    end
  end

  assign push_o = accept && sector_done;

  // position, signature and table lock update
  always_comb begin
    pos_d  = pos_q;
    lock_d = lock_q;
    if (release_i) begin
      lock_d = 1'b0;
    end
    if (push_o && push_kind_o == JOB_TABLE) begin
      lock_d = 1'b1;
    end
    if (accept) begin
      if (sector_done) begin
        pos_d = '0;
      end else if (pos_q < POS_W'(MAX_SECTOR_BYTES)) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sig_lo_q <= '0;
      sig_hi_q <= '0;
      lock_q   <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      lock_q <= lock_d;
      if (accept) begin
        if (sector_done) begin
          sig_lo_q <= '0;
          sig_hi_q <= '0;
        end else begin
          sig_lo_q <= sig_lo_d;
          sig_hi_q <= sig_hi_d;
        end
      end
    end
  end

  // a second table sector can never be queued while the first holds the store
  a_single_table_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_kind_o == JOB_TABLE) |-> !lock_q)
    else $error("table job queued while table store is locked");

endmodule

`default_nettype wire

### hw/rtl/mbrd_jobq.sv
// short job queue between the front and back ends
`default_nettype none

module mbrd_jobq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire mbrd_pkg::job_e       push_kind_i,
  input  wire logic                 pop_i,
  output      logic                 full_o,
  output      mbrd_pkg::job_head_t  head_o
);

  import mbrd_pkg::*;

  localparam int unsigned PTR_W = $clog2(JOBQ_DEPTH);
  localparam int unsigned QCW   = $clog2(JOBQ_DEPTH + 1);

  job_e             slot_q [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   count_q;
  logic             do_pop;

  assign full_o        = (count_q == QCW'(JOBQ_DEPTH));
  assign head_o.valid  = (count_q != '0);
  assign head_o.kind   = slot_q[rd_ptr_q];
  assign do_pop        = pop_i && head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_kind_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QCW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || do_pop))
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

### hw/rtl/mbrd_back.sv
// back end: table sweep, volume checks and result emission
`default_nettype none

module mbrd_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mbrd_pkg::job_head_t                job_i,
  output      logic                               pop_o,
  output      logic                               release_o,
  output      mbrd_pkg::tbl_rd_t                  tbl_rd_o,
  input  wire logic [7:0]                         tbl_rdata_i,
  input  wire logic [mbrd_pkg::SECTOR_SIZE_W-1:0] sector_size_i,
  input  wire logic [mbrd_pkg::DRIVE_COUNT_W-1:0] drive_count_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      mbrd_pkg::out_item_t                out_data_o
);

  import mbrd_pkg::*;

  back_state_e       state_q, state_d;
  logic [TBL_AW-1:0] rd_cnt_q, rd_cnt_d;
  logic              cap_en_q;
  logic [TBL_AW-1:0] cap_addr_q;
  logic [ENT_W-1:0]  ent_q, ent_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  active_q, active_d;
  logic [CNT_W-1:0]  emitted_q, emitted_d;
  logic              ovf_q, ovf_d;

  logic [NUM_ENTRIES-1:0]       flag_q;
  logic [NUM_ENTRIES-1:0][7:0]  type_q;
  logic [NUM_ENTRIES-1:0][31:0] start_q;
  logic [NUM_ENTRIES-1:0][31:0] count_q;

  logic              out_valid_q;
  out_item_t         out_q;
  out_item_t         res;
  logic              load;
  logic              out_free;

  logic [31:0]       cur_start;
  logic [31:0]       cur_count;
  logic [32:0]       cur_sum;
  logic              cur_over;
  logic              table_ok;
  logic              last_ent;
  logic              is_last_part;
  logic [ENT_W-1:0]  cap_ent;
  logic [ENT_OFS_W-1:0] cap_ofs;
  logic [1:0]        cap_lane;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // current entry, 33 bit end sum against the drive size
  assign cur_start    = start_q[ent_q];
  assign cur_count    = count_q[ent_q];
  assign cur_sum      = {1'b0, cur_start} + {1'b0, cur_count};
  assign cur_over     = DRIVE_COUNT_W'(cur_sum) > drive_count_i;
  assign last_ent     = (ent_q == ENT_W'(NUM_ENTRIES - 1));
  assign is_last_part = ((emitted_q + CNT_W'(1)) == used_q);

  // whole table verdict
  assign table_ok = !ovf_q
                 && !((sector_size_i != SECTOR_SIZE_W'(MIN_SECTOR_BYTES))
                      && (type_q[0] == TYPE_HYBRID_CD))
                 && (type_q[0] != TYPE_GPT)
                 && (used_q != '0)
                 && (active_q <= CNT_W'(1));

  // sequencer
  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    ent_d         = ent_q;
    used_d        = used_q;
    active_d      = active_q;
    emitted_d     = emitted_q;
    ovf_d         = ovf_q;
    pop_o         = 1'b0;
    release_o     = 1'b0;
    tbl_rd_o.en   = 1'b0;
    tbl_rd_o.addr = rd_cnt_q;
    load          = 1'b0;
    res           = '0;
    res.outcome   = OUT_NO_VOLUME;
    res.is_final  = 1'b1;

    unique case (state_q)
      B_IDLE: begin
        if (job_i.valid) begin
          unique case (job_i.kind)
            JOB_TABLE: begin
              pop_o    = 1'b1;
              rd_cnt_d = '0;
              state_d  = B_READ;
            end
            JOB_READ_ERROR: begin
              if (out_free) begin
                pop_o       = 1'b1;
                load        = 1'b1;
                res.outcome = OUT_READ_ERROR;
              end
            end
            JOB_NO_VOLUME: begin
              if (out_free) begin
                pop_o       = 1'b1;
                load        = 1'b1;
                res.outcome = OUT_NO_VOLUME;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end

      // one table byte per cycle
      B_READ: begin
        tbl_rd_o.en = 1'b1;
        rd_cnt_d    = rd_cnt_q + TBL_AW'(1);
        if (rd_cnt_q == TBL_AW'(TABLE_BYTES - 1)) begin
          release_o = 1'b1;
          ent_d     = '0;
          used_d    = '0;
          active_d  = '0;
          ovf_d     = 1'b0;
          state_d   = B_EVAL;
        end
      end

      // one entry per cycle, stop counting after the first overrun
      B_EVAL: begin
        if (cur_start != '0 && !ovf_q) begin
          active_d = active_q + CNT_W'(flag_q[ent_q]);
          if (cur_over) begin
            ovf_d = 1'b1;
          end else begin
            used_d = used_q + CNT_W'(1);
          end
        end
        ent_d = ent_q + ENT_W'(1);
        if (last_ent) begin
          state_d = B_DECIDE;
        end
      end

      B_DECIDE: begin
        if (!table_ok) begin
          if (out_free) begin
            load          = 1'b1;
            res.outcome   = OUT_WHOLE_DRIVE;
            res.lba_count = '1;
            state_d       = B_IDLE;
          end
        end else begin
          ent_d     = '0;
          emitted_d = '0;
          state_d   = B_EMIT;
        end
      end

      // one partition transfer per used entry
      B_EMIT: begin
        if (cur_start == '0) begin
          ent_d = ent_q + ENT_W'(1);
          if (last_ent) begin
            state_d = B_IDLE;
          end
        end else if (out_free) begin
          load          = 1'b1;
          res.outcome   = OUT_PARTITION;
          res.slot      = 2'(ent_q);
          res.start_lba = cur_start;
          res.lba_count = cur_count;
          res.type_id   = type_q[ent_q];
          res.is_final  = is_last_part;
          emitted_d     = emitted_q + CNT_W'(1);
          ent_d         = ent_q + ENT_W'(1);
          if (is_last_part || last_ent) begin
            state_d = B_IDLE;
          end
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rd_cnt_q    <= '0;
      cap_en_q    <= 1'b0;
      ent_q       <= '0;
      used_q      <= '0;
      active_q    <= '0;
      emitted_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      cap_en_q  <= tbl_rd_o.en;
      ent_q     <= ent_d;
      used_q    <= used_d;
      active_q  <= active_d;
      emitted_q <= emitted_d;
      ovf_q     <= ovf_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  // capture of the read data into the per entry fields
  assign cap_ent  = cap_addr_q[TBL_AW-1 -: ENT_W];
  assign cap_ofs  = cap_addr_q[ENT_OFS_W-1:0];
  assign cap_lane = cap_addr_q[1:0];

  always_ff @(posedge clk_i) begin
    cap_addr_q <= tbl_rd_o.addr;
    if (cap_en_q) begin
      unique case (cap_ofs) inside
        OFS_FLAG: flag_q[cap_ent] <= tbl_rdata_i[ACTIVE_BIT];
        OFS_TYPE: type_q[cap_ent] <= tbl_rdata_i;
        [OFS_START:OFS_START_END]: start_q[cap_ent][8*cap_lane +: 8] <= tbl_rdata_i;
        [OFS_COUNT:OFS_COUNT_END]: count_q[cap_ent][8*cap_lane +: 8] <= tbl_rdata_i;
        default: ;
      endcase
    end
  end

  a_part_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.outcome == OUT_PARTITION) |-> (out_q.start_lba != '0))
    else $error("partition transfer with zero start");

  a_single_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.outcome != OUT_PARTITION) |-> out_q.is_final)
    else $error("single result transfer not marked final");

  a_release_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_o |=> (state_q == B_EVAL))
    else $error("table released outside the read sweep");

endmodule

`default_nettype wire

### hw/rtl/mbr_partition_table_detect.sv
// A sector ending in no volume or read error gives its transfer from the job queue through the output
// register; a sector with a valid signature gives its first result after the sweep of the 64 byte table
// through the single table ram read port, 4 entry checks and one decision state.
// Throughput: one byte per cycle; intake stalls while the job queue is full, or while the next
// sector reaches the table area before the sweep of the previous table has finished.
// Reset: sector_size 512, drive count 0, position and signatures zero; table ram is not cleared.
`default_nettype none

module mbr_partition_table_detect (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire mbrd_pkg::in_item_t            in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      mbrd_pkg::out_item_t           out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mbrd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mbrd_pkg::APB_DW-1:0]   pwdata,
  output      logic [mbrd_pkg::APB_DW-1:0]   prdata,
  output      logic                          pready
);

  import mbrd_pkg::*;

  logic [SECTOR_SIZE_W-1:0] sector_size_q;
  logic [DRIVE_COUNT_W-1:0] drive_count_q;
  logic                     cfg_wr;
  logic                     reg_idx;

  logic      q_full;
  logic      push;
  job_e      push_kind;
  logic      pop;
  logic      release_tbl;
  job_head_t head;
  tbl_wr_t   tbl_wr;
  tbl_rd_t   tbl_rd;
  logic [7:0] tbl_rdata;

  // configuration registers, 8 byte stride
  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_size_q <= SECTOR_SIZE_RESET;
      drive_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IDX_SECTOR_SIZE: sector_size_q <= pwdata[SECTOR_SIZE_W-1:0];
        REG_IDX_DRIVE_COUNT: drive_count_q <= pwdata[DRIVE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_IDX_SECTOR_SIZE: prdata = APB_DW'(sector_size_q);
      REG_IDX_DRIVE_COUNT: prdata = APB_DW'(drive_count_q);
      default:             prdata = '0;
    endcase
  end

  mbrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .sector_size_i(sector_size_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_kind_o  (push_kind),
    .release_i    (release_tbl),
    .tbl_wr_o     (tbl_wr)
  );

  mbrd_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_BYTES)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_wr.en),
    .waddr_i(tbl_wr.addr),
    .wdata_i(tbl_wr.data),
    .re_i   (tbl_rd.en),
    .raddr_i(tbl_rd.addr),
    .rdata_o(tbl_rdata)
  );

  mbrd_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_kind_i(push_kind),
    .pop_i      (pop),
    .full_o     (q_full),
    .head_o     (head)
  );

  mbrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head),
    .pop_o        (pop),
    .release_o    (release_tbl),
    .tbl_rd_o     (tbl_rd),
    .tbl_rdata_i  (tbl_rdata),
    .sector_size_i(sector_size_q),
    .drive_count_i(drive_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

### verif/mbr_partition_table_detect_test.sv
// self-checking testbench for the mbr partition table detector
`default_nettype none

module mbr_partition_table_detect_test;
  import mbrd_pkg::*;

  // expected volume reports, worked out byte by byte from the sector stream
  class volume_report_board;
    logic [SECTOR_SIZE_W-1:0] sector_size;
    logic [DRIVE_COUNT_W-1:0] drive_count;
    int unsigned              pos;
    logic [7:0]               tbl [TABLE_BYTES];
    logic [7:0]               sig_lo;
    logic [7:0]               sig_hi;
    out_item_t                due_reports [$];
    int unsigned              predicted;
    int unsigned              fails;

    function new();
      sector_size = SECTOR_SIZE_RESET;
      drive_count = '0;
      pos         = 0;
      sig_lo      = '0;
      sig_hi      = '0;
      predicted   = 0;
      fails       = 0;
      foreach (tbl[k]) tbl[k] = '0;
    endfunction

    function void set_reg(input logic idx, input logic [63:0] v);
      if (idx == REG_IDX_SECTOR_SIZE) begin
        sector_size = v[SECTOR_SIZE_W-1:0];
      end else begin
        drive_count = v[DRIVE_COUNT_W-1:0];
      end
    endfunction

    // little-endian word of one table entry
    function logic [31:0] le32(input int e, input int ofs);
      int b;
      b = e * ENTRY_BYTES + ofs;
      return {tbl[b+3], tbl[b+2], tbl[b+1], tbl[b]};
    endfunction

    function void add(input outcome_e oc, input logic [1:0] slot, input logic [31:0] st,
                      input logic [31:0] cnt, input logic [7:0] typ, input logic fin);
      out_item_t r;
      r.outcome   = oc;
      r.slot      = slot;
      r.start_lba = st;
      r.lba_count = cnt;
      r.type_id   = typ;
      r.is_final  = fin;
      due_reports.push_back(r);
      predicted++;
    endfunction

    // note one accepted byte transfer and queue whatever it reports
    function void take_byte(input in_item_t it);
      logic [31:0] st;
      logic [32:0] span;
      int unsigned active;
      int unsigned used;
      int          n;
      int          e;
      logic        fits;
      if (!it.read_error) begin
        if (pos >= TABLE_OFFSET && pos < SIG_OFFSET) begin
          tbl[pos - TABLE_OFFSET] = it.data_byte;
        end else if (pos == SIG_OFFSET) begin
          sig_lo = it.data_byte;
        end else if (pos == SIG_OFFSET + 1) begin
          sig_hi = it.data_byte;
        end
        if (pos < MAX_SECTOR_BYTES) pos++;
      end
      if (!it.read_error && !it.sector_end) return;

      if (sector_size < MIN_SECTOR_BYTES) begin
        add(OUT_NO_VOLUME, 2'd0, '0, '0, '0, 1'b1);
      end else if (it.read_error) begin
        add(OUT_READ_ERROR, 2'd0, '0, '0, '0, 1'b1);
      end else if (sig_lo != SIG_LOW_BYTE || sig_hi != SIG_HIGH_BYTE) begin
        add(OUT_NO_VOLUME, 2'd0, '0, '0, '0, 1'b1);
      end else begin
        // entry checks stop at the first entry running past the drive
        fits   = 1'b1;
        active = 0;
        used   = 0;
        for (e = 0; e < NUM_ENTRIES; e++) begin
          st = le32(e, OFS_START);
          if (fits && st != 0) begin
            if (tbl[e * ENTRY_BYTES + OFS_FLAG][ACTIVE_BIT]) active++;
            span = {1'b0, st} + {1'b0, le32(e, OFS_COUNT)};
            if (DRIVE_COUNT_W'(span) > drive_count) fits = 1'b0;
            else used++;
          end
        end
        if (sector_size != MIN_SECTOR_BYTES && tbl[OFS_TYPE] == TYPE_HYBRID_CD) fits = 1'b0;
        if (tbl[OFS_TYPE] == TYPE_GPT) fits = 1'b0;
        if (used == 0 || active > 1) fits = 1'b0;

        if (!fits) begin
          add(OUT_WHOLE_DRIVE, 2'd0, '0, 32'hFFFF_FFFF, '0, 1'b1);
        end else begin
          n = 0;
          for (e = 0; e < NUM_ENTRIES; e++) begin
            st = le32(e, OFS_START);
            if (st != 0) begin
              n++;
              add(OUT_PARTITION, 2'(e), st, le32(e, OFS_COUNT),
                  tbl[e * ENTRY_BYTES + OFS_TYPE], n == used);
            end
          end
        end
      end
      pos    = 0;
      sig_lo = '0;
      sig_hi = '0;
    endfunction

    function void cmp(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
        $error("%s expected 0x%0h got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    // compare one accepted result with the oldest expected report
    function void match_report(input out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        $error("result with none expected: outcome %0d slot %0d", got.outcome, got.slot);
        fails++;
        return;
      end
      want = due_reports.pop_front();
      cmp("outcome", 32'(want.outcome), 32'(got.outcome));
      cmp("slot", 32'(want.slot), 32'(got.slot));
      cmp("start_lba", want.start_lba, got.start_lba);
      cmp("lba_count", want.lba_count, got.lba_count);
      cmp("type_id", 32'(want.type_id), 32'(got.type_id));
      cmp("is_final", 32'(want.is_final), 32'(got.is_final));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  in_item_t          in_data_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  out_item_t         out_data_o;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int                 gap_pct   = 12;
  int                 stall_pct = 53;
  logic [7:0]         img [512];
  volume_report_board sb;

  mbr_partition_table_detect u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watch both channels for completed transfers
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.match_report(out_data_o);
    end
  end

  // one byte transfer, with an occasional gap in front of it
  task automatic push_item(input logic [7:0] d, input logic re, input logic se);
    in_item_t it;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    it.data_byte = d;
    it.read_error = re;
    it.sector_end = se;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold the sender until every queued report has come out
  task automatic drain_reports(input int hold);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  // register write, then a read back of the same register
  task automatic write_reg(input logic idx, input logic [63:0] v);
    logic [63:0] kept;
    kept = (idx == REG_IDX_SECTOR_SIZE) ? 64'(v[SECTOR_SIZE_W-1:0])
                                        : 64'(v[DRIVE_COUNT_W-1:0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      $error("prdata expected 0x%0h got 0x%0h", kept, prdata);
      sb.fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_noise();
    foreach (img[k]) img[k] = 8'($urandom);
  endtask

  task automatic set_sig(input logic [7:0] lo, input logic [7:0] hi);
    img[SIG_OFFSET]     = lo;
    img[SIG_OFFSET + 1] = hi;
  endtask

  task automatic set_entry(input int e, input logic [7:0] flag, input logic [7:0] typ,
                           input logic [31:0] st, input logic [31:0] cnt);
    int b;
    int k;
    b = TABLE_OFFSET + e * ENTRY_BYTES;
    img[b + OFS_FLAG] = flag;
    img[b + OFS_TYPE] = typ;
    for (k = 0; k < 4; k++) begin
      img[b + OFS_START + k] = st[8*k +: 8];
      img[b + OFS_COUNT + k] = cnt[8*k +: 8];
    end
  endtask

  // signed sector with all four entries unused
  task automatic blank_table();
    int e;
    fill_noise();
    for (e = 0; e < NUM_ENTRIES; e++) set_entry(e, 8'h00, 8'h00, '0, '0);
    set_sig(SIG_LOW_BYTE, SIG_HIGH_BYTE);
  endtask

  // signed sector with random entries, biased towards edge values
  task automatic good_table();
    int          e;
    logic [31:0] st;
    logic [31:0] cnt;
    logic [7:0]  flag;
    logic [7:0]  typ;
    fill_noise();
    for (e = 0; e < NUM_ENTRIES; e++) begin
      case ($urandom_range(7))
        0, 1:    st = '0;
        2:       st = $urandom_range(32'hFFFF, 1);
        3:       st = '1;
        default: st = $urandom;
      endcase
      case ($urandom_range(5))
        0:       cnt = '0;
        1:       cnt = '1;
        2, 3:    cnt = $urandom_range(32'hFFFFF);
        default: cnt = $urandom;
      endcase
      flag = 8'($urandom);
      flag[ACTIVE_BIT] = ($urandom_range(3) == 0);
      typ = 8'($urandom);
      if (e == 0) begin
        case ($urandom_range(15))
          0:       typ = TYPE_GPT;
          1:       typ = TYPE_HYBRID_CD;
          default: ;
        endcase
      end
      set_entry(e, flag, typ, st, cnt);
    end
    set_sig(SIG_LOW_BYTE, SIG_HIGH_BYTE);
  endtask

  // send the image as a sector of len bytes; a read error replaces byte err_at
  task automatic send_sector(input int len, input int err_at);
    int i;
    for (i = 0; i < len; i++) begin
      if (i == err_at) begin
        push_item(8'($urandom), 1'b1, 1'($urandom_range(1)));
        return;
      end
      push_item(i < 512 ? img[i] : 8'($urandom), 1'b0, i == len - 1);
    end
  endtask

  // mostly well-formed sectors, the rest short, failed or badly signed
  task automatic random_sector();
    int k;
    k = $urandom_range(99);
    if (k < 65) begin
      good_table();
      send_sector(k < 55 ? 512 : $urandom_range(600, 513), -1);
    end else if (k < 75) begin
      fill_noise();
      send_sector($urandom_range(520, 1), -1);
    end else if (k < 87) begin
      good_table();
      send_sector(512, $urandom_range(520, 0));
    end else begin
      good_table();
      img[SIG_OFFSET + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      send_sector(512, -1);
    end
  endtask

  task automatic run_random(input int want);
    int unsigned first;
    first = sb.predicted;
    while (sb.predicted - first < want) random_sector();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 512 byte sectors on an empty drive
    send_sector(1, 0);
    push_item(8'hFF, 1'b1, 1'b1);
    fill_noise();
    send_sector(1, -1);
    fill_noise();
    send_sector(10, -1);
    blank_table();
    set_entry(1, 8'h80, 8'h07, 32'd100, 32'd50);
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h00, 8'h0C, 32'd1, 32'd1);
    set_sig(SIG_HIGH_BYTE, SIG_LOW_BYTE);
    send_sector(512, -1);
    drain_reports(8);

    // largest drive: nothing runs past its end
    write_reg(REG_IDX_DRIVE_COUNT, 64'hFFFF_FFFF_FFFF);
    blank_table();
    set_entry(3, 8'h00, 8'hFF, 32'd1, 32'd0);
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h80, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_entry(1, 8'h7F, 8'hCD, 32'd1, 32'd2);
    set_entry(2, 8'h00, 8'h01, 32'h8000_0000, 32'h7FFF_FFFF);
    set_entry(3, 8'h00, 8'hEF, 32'd2, 32'd0);
    send_sector(512, -1);
    blank_table();
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h80, 8'h07, 32'd1, 32'd1);
    set_entry(2, 8'hFF, 8'h0B, 32'd5, 32'd5);
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h00, TYPE_GPT, 32'd1, 32'd1);
    send_sector(512, -1);
    blank_table();
    set_entry(1, 8'h00, TYPE_GPT, 32'd1, 32'd1);
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h00, TYPE_HYBRID_CD, 32'd1, 32'd1);
    send_sector(512, -1);
    // position saturates well before the end of this one
    blank_table();
    set_entry(0, 8'h80, 8'h07, 32'd64, 32'd1000);
    send_sector(MAX_SECTOR_BYTES + 104, -1);
    blank_table();
    set_entry(0, 8'h00, 8'h83, 32'd9, 32'd9);
    send_sector(512, 480);
    blank_table();
    set_entry(2, 8'h00, 8'h83, 32'd9, 32'd9);
    send_sector(512, 511);
    drain_reports(8);

    // drive of exactly 2^32 sectors around the 33 bit end sum
    write_reg(REG_IDX_DRIVE_COUNT, 64'h1_0000_0000);
    blank_table();
    set_entry(0, 8'h00, 8'h0C, 32'hFFFF_FFFF, 32'd1);
    send_sector(512, -1);
    blank_table();
    set_entry(0, 8'h00, 8'h0C, 32'hFFFF_FFFF, 32'd2);
    send_sector(512, -1);
    blank_table();
    set_entry(1, 8'h00, 8'h0C, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sector(512, -1);
    drain_reports(8);

    // largest sector size: the hybrid cd marker now matters
    write_reg(REG_IDX_SECTOR_SIZE, 64'hFFFF);
    blank_table();
    set_entry(0, 8'h00, TYPE_HYBRID_CD, 32'd1, 32'd1);
    send_sector(512, -1);
    drain_reports(8);

    // sector sizes under 512 report no volume, read errors included
    write_reg(REG_IDX_SECTOR_SIZE, 64'h0);
    blank_table();
    set_entry(0, 8'h00, 8'h07, 32'd1, 32'd1);
    send_sector(512, -1);
    send_sector(5, 2);
    drain_reports(8);
    write_reg(REG_IDX_SECTOR_SIZE, 64'd511);
    send_sector(3, 0);
    blank_table();
    set_entry(0, 8'h00, 8'h07, 32'd1, 32'd1);
    send_sector(512, -1);
    drain_reports(8);

    // random sectors, sender rarely idle, receiver often stalled
    write_reg(REG_IDX_SECTOR_SIZE, 64'd512);
    write_reg(REG_IDX_DRIVE_COUNT, 64'h1_8000_0000);
    run_random(20);
    drain_reports(8);

    // roles swapped, a larger sector size on the largest drive
    gap_pct   = 53;
    stall_pct = 12;
    write_reg(REG_IDX_SECTOR_SIZE, 64'd2048);
    write_reg(REG_IDX_DRIVE_COUNT, 64'hFFFF_FFFF_FFFF);
    run_random(20);
    drain_reports(8);

    // no idling at all, with a full pause half way
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_IDX_SECTOR_SIZE, 64'd512);
    write_reg(REG_IDX_DRIVE_COUNT, 64'h1_0000_0000);
    run_random(10);
    drain_reports(0);
    run_random(12);

    drain_reports(100);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
